// ===== rtl/core/mbd_pkg.sv =====
package mbd_pkg;

   // operation codes
   localparam logic [2:0] OP_READ  = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_FRAME = 3'd2;
   localparam logic [2:0] OP_KEYS  = 3'd3;
   localparam logic [2:0] OP_PIXEL = 3'd4;

   // memory
   localparam int          RAM_BYTES_DEFAULT = 32768;
   localparam logic [15:0] RAM_LIMIT         = 16'h8000;

   // port addresses
   localparam logic [15:0] ADDR_CRTC_SEL  = 16'hFE00;
   localparam logic [15:0] ADDR_CRTC_DATA = 16'hFE01;
   localparam logic [15:0] ADDR_SYNC      = 16'hFE4D;
   localparam logic [15:0] ADDR_SCAN      = 16'hFE4F;
   localparam logic [15:0] ADDR_STUB_A    = 16'hFFEE;
   localparam logic [15:0] ADDR_STUB_B    = 16'hFFF4;
   localparam logic [15:0] ADDR_VEC_LO    = 16'hFFFC;
   localparam logic [15:0] ADDR_VEC_HI    = 16'hFFFD;

   // CRTC register numbers
   localparam logic [7:0] CRTC_START_HIGH = 8'h0C;
   localparam logic [7:0] CRTC_START_LOW  = 8'h0D;

   // scan codes
   localparam logic [6:0] SCAN_Z      = 7'h61;
   localparam logic [6:0] SCAN_X      = 7'h42;
   localparam logic [6:0] SCAN_RETURN = 7'h49;
   localparam logic [6:0] SCAN_SPACE  = 7'h62;

   localparam logic [7:0]  RTS_OPCODE      = 8'h60;
   localparam logic [7:0]  SCAN_MISS_BIT   = 8'h80;
   localparam logic [7:0]  SYNC_FRAME_BIT  = 8'h02;
   localparam logic [7:0]  START_HIGH_RST  = 8'h08;
   localparam logic [7:0]  START_HIGH_ALT  = 8'h0C;
   localparam logic [15:0] RESET_VECTOR_RST = 16'h1800;

   // request info carried alongside the RAM read
   typedef struct packed {
      logic       use_ram;   // read data comes from RAM
      logic       is_pixel;  // pixel fetch, select one bit of RAM byte
      logic [2:0] bit_sel;   // pixel column within the byte
      logic [7:0] imm_data;  // read data from a port, vector or stub
   } stage_info_type;

endpackage

// ===== rtl/core/micro_bus_io_decoder_core.sv =====
// Response path: RAM read at the request accept edge, then the output register, which
// drives rsp_valid; while a response stalls, the next request waits in the read stage.
// Throughput: one request per cycle while req_stall is low; the RAM has one write
// and one read port; the output register plus the read stage absorb a stalled response.
// Reset (synchronous, active high): clears the pipeline and all I/O registers,
// reset vector to 0x1800, screen start high to 0x08; RAM contents are not cleared.
module micro_bus_io_decoder_core #(
   parameter int RAM_BYTES = mbd_pkg::RAM_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [3:0]  req_key_bits,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_pixel_on,
   // reset vector register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int AW = $clog2(RAM_BYTES);

   logic                    accept;
   logic                    ram_wr_en, ram_rd_en;
   logic [AW-1:0]           ram_wr_addr, ram_rd_addr;
   logic [7:0]              ram_q;
   mbd_pkg::stage_info_type info;

   assign accept = req_valid && !req_stall;

   // Stage 0: decode, update I/O registers, issue the RAM write or read.
   // Writes and reads happen in request order at the accept edge, so a read
   // issued in the cycle after a write to the same byte already sees the new data.
   mbd_regs #(
      .AW (AW)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (req_operation),
      .address     (req_address),
      .write_data  (req_write_data),
      .key_bits    (req_key_bits),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ram_wr_en   (ram_wr_en),
      .ram_rd_en   (ram_rd_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_addr (ram_rd_addr),
      .info        (info)
   );

   // Main RAM and screen memory; read data holds until the next read.
   mbd_ram #(
      .DEPTH (RAM_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_write_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   // Stage 1 merges RAM data with the port data, stage 2 is the output register.
   mbd_outq u_outq (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .info          (info),
      .ram_q         (ram_q),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_pixel_on  (rsp_pixel_on)
   );

endmodule

// ===== rtl/core/mbd_ram.sv =====
module mbd_ram #(
   parameter int DEPTH = mbd_pkg::RAM_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/mbd_regs.sv =====
module mbd_regs #(
   parameter int AW = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [2:0]             operation,
   input  logic [15:0]            address,
   input  logic [7:0]             write_data,
   input  logic [3:0]             key_bits,
   input  logic [7:0]             pixel_x,
   input  logic [7:0]             pixel_y,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   output logic                   ram_wr_en,
   output logic                   ram_rd_en,
   output logic [AW-1:0]          ram_wr_addr,
   output logic [AW-1:0]          ram_rd_addr,
   output mbd_pkg::stage_info_type info
);

   logic [7:0]  crtc_select_ff, crtc_select_in;
   logic [7:0]  start_high_ff, start_high_in;
   logic [7:0]  start_low_ff, start_low_in;
   logic [7:0]  sync_flags_ff, sync_flags_in;
   logic [7:0]  scan_latch_ff, scan_latch_in;
   logic [3:0]  held_keys_ff, held_keys_in;
   logic [15:0] reset_vector_ff, reset_vector_in;

   logic        is_read, is_write, is_pixel, below_ram;
   logic [6:0]  scan_code;
   logic        scan_hit;
   logic [7:0]  scan_value;
   logic [7:0]  port_data;
   logic [14:0] pixel_addr;

   assign is_read   = (operation == mbd_pkg::OP_READ);
   assign is_write  = (operation == mbd_pkg::OP_WRITE);
   assign is_pixel  = (operation == mbd_pkg::OP_PIXEL);
   assign below_ram = (address < mbd_pkg::RAM_LIMIT);

   // keyboard scan port
   assign scan_code = scan_latch_ff[6:0];
   always_comb begin
      unique case (scan_code)
         mbd_pkg::SCAN_Z:      scan_hit = held_keys_ff[0];
         mbd_pkg::SCAN_X:      scan_hit = held_keys_ff[1];
         mbd_pkg::SCAN_RETURN: scan_hit = held_keys_ff[2];
         mbd_pkg::SCAN_SPACE:  scan_hit = held_keys_ff[3];
         default:              scan_hit = 1'b0;
      endcase
   end
   assign scan_value = scan_hit ? {1'b0, scan_code} : (scan_latch_ff | mbd_pkg::SCAN_MISS_BIT);

   always_comb begin
      unique case (address)
         mbd_pkg::ADDR_SYNC:   port_data = sync_flags_ff;
         mbd_pkg::ADDR_SCAN:   port_data = scan_value;
         mbd_pkg::ADDR_STUB_A: port_data = mbd_pkg::RTS_OPCODE;
         mbd_pkg::ADDR_STUB_B: port_data = mbd_pkg::RTS_OPCODE;
         mbd_pkg::ADDR_VEC_LO: port_data = reset_vector_ff[7:0];
         mbd_pkg::ADDR_VEC_HI: port_data = reset_vector_ff[15:8];
         default:              port_data = 8'h00;
      endcase
   end

   // screen in character-cell order: base | row cell | column cell | line
   assign pixel_addr = {1'b1, (start_high_ff == mbd_pkg::START_HIGH_ALT),
                        pixel_y[7:3], pixel_x[7:3], pixel_y[2:0]};

   assign ram_wr_en   = accept && is_write && below_ram;
   assign ram_wr_addr = address[AW-1:0];
   assign ram_rd_en   = accept && ((is_read && below_ram) || is_pixel);
   assign ram_rd_addr = is_pixel ? AW'(pixel_addr) : address[AW-1:0];

   always_comb begin
      info.use_ram  = is_read && below_ram;
      info.is_pixel = is_pixel;
      info.bit_sel  = pixel_x[2:0];
      info.imm_data = is_read ? port_data : 8'h00;
   end

   always_comb begin
      crtc_select_in  = crtc_select_ff;
      start_high_in   = start_high_ff;
      start_low_in    = start_low_ff;
      sync_flags_in   = sync_flags_ff;
      scan_latch_in   = scan_latch_ff;
      held_keys_in    = held_keys_ff;
      reset_vector_in = csr_wr_en ? csr_wr_data : reset_vector_ff;
      if (accept) begin
         case (operation)
            mbd_pkg::OP_WRITE: begin
               case (address)
                  mbd_pkg::ADDR_CRTC_SEL: crtc_select_in = write_data;
                  mbd_pkg::ADDR_CRTC_DATA: begin
                     if (crtc_select_ff == mbd_pkg::CRTC_START_HIGH) begin
                        start_high_in = write_data;
                     end else if (crtc_select_ff == mbd_pkg::CRTC_START_LOW) begin
                        start_low_in = write_data;
                     end
                  end
                  mbd_pkg::ADDR_SYNC: sync_flags_in = sync_flags_ff & ~write_data;
                  mbd_pkg::ADDR_SCAN: scan_latch_in = write_data;
                  default: ;
               endcase
            end
            mbd_pkg::OP_FRAME: sync_flags_in = sync_flags_ff | mbd_pkg::SYNC_FRAME_BIT;
            mbd_pkg::OP_KEYS:  held_keys_in = key_bits;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crtc_select_ff  <= 8'h00;
         start_high_ff   <= mbd_pkg::START_HIGH_RST;
         start_low_ff    <= 8'h00;
         sync_flags_ff   <= 8'h00;
         scan_latch_ff   <= 8'h00;
         held_keys_ff    <= 4'h0;
         reset_vector_ff <= mbd_pkg::RESET_VECTOR_RST;
      end else begin
         crtc_select_ff  <= crtc_select_in;
         start_high_ff   <= start_high_in;
         start_low_ff    <= start_low_in;
         sync_flags_ff   <= sync_flags_in;
         scan_latch_ff   <= scan_latch_in;
         held_keys_ff    <= held_keys_in;
         reset_vector_ff <= reset_vector_in;
      end
   end

endmodule

// ===== rtl/core/mbd_outq.sv =====
module mbd_outq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  mbd_pkg::stage_info_type info,
   input  logic [7:0]              ram_q,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_read_data,
   output logic                    rsp_pixel_on
);

   logic                    s1_valid_ff, s1_valid_in;
   mbd_pkg::stage_info_type s1_info_ff, s1_info_in;
   logic                    out_valid_ff, out_valid_in;
   logic [7:0]              out_data_ff, out_data_in;
   logic                    out_pixel_ff, out_pixel_in;
   logic                    out_load, s1_move;

   // output register free or being drained this cycle
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_load;
   assign req_stall = s1_valid_ff && !out_load;

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      s1_info_in   = accept ? info : s1_info_ff;
      out_valid_in = out_load ? s1_valid_ff : out_valid_ff;
      out_data_in  = out_data_ff;
      out_pixel_in = out_pixel_ff;
      if (s1_move) begin
         out_data_in  = s1_info_ff.use_ram ? ram_q : s1_info_ff.imm_data;
         out_pixel_in = s1_info_ff.is_pixel && ram_q[3'd7 - s1_info_ff.bit_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_info_ff   <= s1_info_in;
      out_data_ff  <= out_data_in;
      out_pixel_ff <= out_pixel_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;
   assign rsp_pixel_on  = out_pixel_ff;

endmodule

// ===== verif/tb_micro_bus_io_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_micro_bus_io_decoder_core;

   // spare operation codes: no effect, result is all zero
   localparam logic [2:0]  OP_SPARE_LO        = 3'd5;
   localparam logic [2:0]  OP_SPARE_HI        = 3'd7;
   // port-page address that decodes to nothing
   localparam logic [15:0] ADDR_UNMAPPED_PORT = 16'hFE43;
   // screen bases picked by the start-high register
   localparam logic [15:0] SCREEN_BASE_STD    = 16'h4000;
   localparam logic [15:0] SCREEN_BASE_ALT    = 16'h6000;
   localparam int          SCREEN_BYTES       = 8192;
   localparam int          RAM_WORDS          = mbd_pkg::RAM_BYTES_DEFAULT;

   localparam int PHASE_ITEMS   = 430;
   localparam int SETTLE_CYCLES = 6;        // margin after the last result, leave room
   localparam int HOLD_AT_A     = 300;      // result counts that start a long stall
   localparam int HOLD_AT_B     = 900;
   localparam int LONG_HOLD     = 40;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [3:0]  keys;
      logic [7:0]  px;
      logic [7:0]  py;
      logic        drain;   // sender waits for all results before offering this one
   } bus_request_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       pixel_on;
   } bus_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [2:0]  req_operation  = '0;
   logic [15:0] req_address    = '0;
   logic [7:0]  req_write_data = '0;
   logic [3:0]  req_key_bits   = '0;
   logic [7:0]  req_pixel_x    = '0;
   logic [7:0]  req_pixel_y    = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_pixel_on;
   logic        csr_wr_en      = 1'b0;
   logic [15:0] csr_wr_data    = '0;

   micro_bus_io_decoder_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_key_bits   (req_key_bits),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_pixel_on   (rsp_pixel_on),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Decoder state mirror, advanced once per accepted request
   // ---------------------------------------------------------------
   logic [7:0]  ram_image [0:RAM_WORDS-1];   // X until written
   logic [7:0]  crtc_sel_m      = '0;
   logic [7:0]  start_high_m    = mbd_pkg::START_HIGH_RST;
   logic [7:0]  start_low_m     = '0;        // stored only, never steers the screen
   logic [7:0]  sync_flags_m    = '0;
   logic [7:0]  scan_latch_m    = '0;
   logic [3:0]  held_keys_m     = '0;
   logic [15:0] reset_vector_m  = mbd_pkg::RESET_VECTOR_RST;

   function automatic bus_result_type decode_bus_request(input bus_request_type r);
      bus_result_type res;
      logic [6:0]  code;
      logic        hit;
      logic [15:0] pix_addr;
      logic [7:0]  pix_byte;
      res.read_data = '0;
      res.pixel_on  = 1'b0;
      case (r.op)
         mbd_pkg::OP_READ: begin
            case (r.addr)
               mbd_pkg::ADDR_SYNC: res.read_data = sync_flags_m;
               mbd_pkg::ADDR_SCAN: begin
                  // top bit of the latch is ignored for the match
                  code = scan_latch_m[6:0];
                  hit  = (code == mbd_pkg::SCAN_Z      && held_keys_m[0]) ||
                         (code == mbd_pkg::SCAN_X      && held_keys_m[1]) ||
                         (code == mbd_pkg::SCAN_RETURN && held_keys_m[2]) ||
                         (code == mbd_pkg::SCAN_SPACE  && held_keys_m[3]);
                  res.read_data = hit ? {1'b0, code}
                                      : (scan_latch_m | mbd_pkg::SCAN_MISS_BIT);
               end
               mbd_pkg::ADDR_STUB_A, mbd_pkg::ADDR_STUB_B:
                  res.read_data = mbd_pkg::RTS_OPCODE;
               mbd_pkg::ADDR_VEC_LO: res.read_data = reset_vector_m[7:0];
               mbd_pkg::ADDR_VEC_HI: res.read_data = reset_vector_m[15:8];
               default: begin
                  if (r.addr < mbd_pkg::RAM_LIMIT) res.read_data = ram_image[r.addr[14:0]];
               end
            endcase
         end
         mbd_pkg::OP_WRITE: begin
            case (r.addr)
               mbd_pkg::ADDR_CRTC_SEL: crtc_sel_m = r.data;
               mbd_pkg::ADDR_CRTC_DATA: begin
                  if (crtc_sel_m == mbd_pkg::CRTC_START_HIGH) start_high_m = r.data;
                  else if (crtc_sel_m == mbd_pkg::CRTC_START_LOW) start_low_m = r.data;
               end
               mbd_pkg::ADDR_SYNC: sync_flags_m = sync_flags_m & ~r.data;
               mbd_pkg::ADDR_SCAN: scan_latch_m = r.data;
               default: begin
                  // upper half other than the ports: dropped
                  if (r.addr < mbd_pkg::RAM_LIMIT) ram_image[r.addr[14:0]] = r.data;
               end
            endcase
         end
         mbd_pkg::OP_FRAME: sync_flags_m = sync_flags_m | mbd_pkg::SYNC_FRAME_BIT;
         mbd_pkg::OP_KEYS:  held_keys_m = r.keys;
         mbd_pkg::OP_PIXEL: begin
            // character-cell layout: 8 lines per cell row, 256 bytes per cell row
            pix_addr = ((start_high_m == mbd_pkg::START_HIGH_ALT) ? SCREEN_BASE_ALT
                                                                 : SCREEN_BASE_STD)
                       + {3'd0, r.py[7:3], 8'd0} + {8'd0, r.px[7:3], 3'd0}
                       + {13'd0, r.py[2:0]};
            pix_byte = ram_image[pix_addr[14:0]];
            res.pixel_on = pix_byte[3'd7 - r.px[2:0]];
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus planning. Plans are made in issue order, so the plan
   // shadow (RAM written map, CRTC select, start high) matches what the
   // block will hold when each request executes. Used to keep reads and
   // pixel fetches on RAM bytes that were written.
   // ---------------------------------------------------------------
   bus_request_type pending [$];
   bus_result_type  result_fifo [$];

   bit   plan_written [0:RAM_WORDS-1];
   int   plan_written_list [$];
   logic [7:0] plan_crtc       = '0;
   logic [7:0] plan_start_high = mbd_pkg::START_HIGH_RST;
   bit   drain_next = 1'b0;
   int   planned    = 0;

   function automatic logic [15:0] rnd16();
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(0, 8'hFF));
   endfunction

   function automatic logic [3:0] rnd4();
      return 4'($urandom_range(0, 4'hF));
   endfunction

   function automatic void add_request(input logic [2:0] op, input logic [15:0] addr,
                                       input logic [7:0] data, input logic [3:0] keys,
                                       input logic [7:0] px, input logic [7:0] py);
      bus_request_type r;
      r.op = op; r.addr = addr; r.data = data; r.keys = keys;
      r.px = px; r.py = py; r.drain = drain_next;
      drain_next = 1'b0;
      pending.push_back(r);
      planned++;
      if (op == mbd_pkg::OP_WRITE) begin
         if (addr == mbd_pkg::ADDR_CRTC_SEL) plan_crtc = data;
         else if (addr == mbd_pkg::ADDR_CRTC_DATA && plan_crtc == mbd_pkg::CRTC_START_HIGH)
            plan_start_high = data;
         else if (addr < mbd_pkg::RAM_LIMIT && !plan_written[addr[14:0]]) begin
            plan_written[addr[14:0]] = 1'b1;
            plan_written_list.push_back(int'(addr));
         end
      end
   endfunction

   function automatic logic [15:0] pick_port_address();
      case ($urandom_range(0, 9))
         0: return mbd_pkg::ADDR_SYNC;
         1: return mbd_pkg::ADDR_SCAN;
         2: return mbd_pkg::ADDR_STUB_A;
         3: return mbd_pkg::ADDR_STUB_B;
         4: return mbd_pkg::ADDR_VEC_LO;
         5: return mbd_pkg::ADDR_VEC_HI;
         6: return mbd_pkg::ADDR_CRTC_SEL;
         7: return mbd_pkg::ADDR_CRTC_DATA;
         8: return ADDR_UNMAPPED_PORT;
         default: return mbd_pkg::RAM_LIMIT | 16'($urandom_range(0, 16'h7FFF));
      endcase
   endfunction

   function automatic void plan_ram_write();
      logic [15:0] a;
      // mostly screen area so pixel fetches find written bytes
      if ($urandom_range(0, 9) < 7) a = SCREEN_BASE_STD + 16'($urandom_range(0, 16'h3FFF));
      else a = 16'($urandom_range(0, 16'h7FFF));
      add_request(mbd_pkg::OP_WRITE, a, rnd8(), rnd4(), rnd8(), rnd8());
   endfunction

   function automatic void plan_read();
      logic [15:0] a;
      if (plan_written_list.size() > 0 && $urandom_range(0, 9) < 6)
         a = 16'(plan_written_list[$urandom_range(0, plan_written_list.size() - 1)]);
      else
         a = pick_port_address();
      add_request(mbd_pkg::OP_READ, a, rnd8(), rnd4(), rnd8(), rnd8());
   endfunction

   function automatic void plan_pixel_fetch();
      int base;
      int a;
      int off;
      int tries;
      bit found;
      base  = int'((plan_start_high == mbd_pkg::START_HIGH_ALT) ? SCREEN_BASE_ALT
                                                                : SCREEN_BASE_STD);
      found = 1'b0;
      a     = 0;
      for (tries = 0; tries < 8 && !found && plan_written_list.size() > 0; tries++) begin
         a = plan_written_list[$urandom_range(0, plan_written_list.size() - 1)];
         found = (a >= base) && (a < base + SCREEN_BYTES);
      end
      if (!found) begin
         a = base + $urandom_range(0, SCREEN_BYTES - 1);
         add_request(mbd_pkg::OP_WRITE, 16'(a), rnd8(), rnd4(), rnd8(), rnd8());
      end
      // invert the cell layout to get a pixel inside that byte
      off = a - base;
      add_request(mbd_pkg::OP_PIXEL, rnd16(), rnd8(), rnd4(),
                  8'(((off >> 3) & 31) * 8 + $urandom_range(0, 7)),
                  8'((off >> 8) * 8 + (off & 7)));
   endfunction

   // latch a scan code, set the held keys, read the scan port
   function automatic void plan_scan_check();
      logic [7:0] code;
      case ($urandom_range(0, 4))
         0: code = {1'b0, mbd_pkg::SCAN_Z};
         1: code = {1'b0, mbd_pkg::SCAN_X};
         2: code = {1'b0, mbd_pkg::SCAN_RETURN};
         3: code = {1'b0, mbd_pkg::SCAN_SPACE};
         default: code = rnd8();
      endcase
      if ($urandom_range(0, 3) == 0) code[7] = 1'b1;
      add_request(mbd_pkg::OP_WRITE, mbd_pkg::ADDR_SCAN, code, rnd4(), rnd8(), rnd8());
      add_request(mbd_pkg::OP_KEYS, rnd16(), rnd8(), rnd4(), rnd8(), rnd8());
      add_request(mbd_pkg::OP_READ, mbd_pkg::ADDR_SCAN, rnd8(), rnd4(), rnd8(), rnd8());
   endfunction

   function automatic void plan_sync_check();
      add_request(mbd_pkg::OP_FRAME, rnd16(), rnd8(), rnd4(), rnd8(), rnd8());
      add_request(mbd_pkg::OP_READ, mbd_pkg::ADDR_SYNC, rnd8(), rnd4(), rnd8(), rnd8());
      add_request(mbd_pkg::OP_WRITE, mbd_pkg::ADDR_SYNC, rnd8(), rnd4(), rnd8(), rnd8());
      add_request(mbd_pkg::OP_READ, mbd_pkg::ADDR_SYNC, rnd8(), rnd4(), rnd8(), rnd8());
   endfunction

   // select a CRTC register, write it, then fetch a few pixels
   function automatic void plan_screen_switch();
      logic [7:0] sel;
      logic [7:0] val;
      int n;
      case ($urandom_range(0, 5))
         0, 1, 2: sel = mbd_pkg::CRTC_START_HIGH;
         3, 4:    sel = mbd_pkg::CRTC_START_LOW;
         default: sel = rnd8();
      endcase
      case ($urandom_range(0, 3))
         0, 1:    val = mbd_pkg::START_HIGH_ALT;
         2:       val = mbd_pkg::START_HIGH_RST;
         default: val = rnd8();
      endcase
      add_request(mbd_pkg::OP_WRITE, mbd_pkg::ADDR_CRTC_SEL, sel, rnd4(), rnd8(), rnd8());
      add_request(mbd_pkg::OP_WRITE, mbd_pkg::ADDR_CRTC_DATA, val, rnd4(), rnd8(), rnd8());
      for (n = $urandom_range(1, 4); n > 0; n--) plan_pixel_fetch();
   endfunction

   function automatic void plan_random_phase(input int count);
      int stop_at;
      int pick;
      stop_at = planned + count;
      while (planned < stop_at) begin
         if ($urandom_range(0, 59) == 0) drain_next = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 20)      plan_ram_write();
         else if (pick < 38) plan_read();
         else if (pick < 56) plan_pixel_fetch();
         else if (pick < 64) plan_scan_check();
         else if (pick < 70) plan_sync_check();
         else if (pick < 76) plan_screen_switch();
         else if (pick < 82) add_request(mbd_pkg::OP_WRITE, pick_port_address(), rnd8(),
                                         rnd4(), rnd8(), rnd8());
         else if (pick < 87) add_request(mbd_pkg::OP_FRAME, rnd16(), rnd8(), rnd4(),
                                         rnd8(), rnd8());
         else if (pick < 93) add_request(mbd_pkg::OP_KEYS, rnd16(), rnd8(), rnd4(),
                                         rnd8(), rnd8());
         else if (pick < 96) add_request(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                                         rnd16(), rnd8(), rnd4(), rnd8(), rnd8());
         else                add_request(mbd_pkg::OP_WRITE,
                                         mbd_pkg::RAM_LIMIT | 16'($urandom_range(0, 16'h7FFF)),
                                         rnd8(), rnd4(), rnd8(), rnd8());
      end
   endfunction

   // ---------------------------------------------------------------
   // Gaps: draw_gap picks a random idle gap per request when enabled, none otherwise
   // ---------------------------------------------------------------
   bit idle_on = 1'b1;

   function automatic int draw_gap();
      return idle_on ? $urandom_range(0, 5) : 0;
   endfunction

   // ---------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------
   bus_request_type cur_req;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            // request taken at this edge: predict its result now
            result_fifo.push_back(decode_bus_request(cur_req));
            gap_left = draw_gap();
         end else if (gap_left > 0) begin
            gap_left--;
         end
         if (gap_left == 0 && pending.size() > 0 &&
             !(pending[0].drain && result_fifo.size() != 0)) begin
            cur_req = pending.pop_front();
            req_operation  <= cur_req.op;
            req_address    <= cur_req.addr;
            req_write_data <= cur_req.data;
            req_key_bits   <= cur_req.keys;
            req_pixel_x    <= cur_req.px;
            req_pixel_y    <= cur_req.py;
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response stall: random per result, plus two long holds so the
   // pipeline backs up into req_stall
   // ---------------------------------------------------------------
   int stall_left = 0;
   int hold_left = 0;
   int results_released = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_released++;
            stall_left = draw_gap();
            if (results_released == HOLD_AT_A || results_released == HOLD_AT_B)
               hold_left = LONG_HOLD;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         if (hold_left > 0) hold_left--;
         rsp_stall <= (stall_left > 0) || (hold_left > 0);
      end
   end

   // ---------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------
   bus_result_type want;
   int failures = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_fifo.size() == 0) begin
            $display("%0t: unexpected response read_data=%h pixel_on=%b",
                     $time, rsp_read_data, rsp_pixel_on);
            failures++;
         end else begin
            want = result_fifo.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $display("%0t: read_data mismatch expected %h actual %h",
                        $time, want.read_data, rsp_read_data);
               failures++;
            end
            if (rsp_pixel_on !== want.pixel_on) begin
               $display("%0t: pixel_on mismatch expected %b actual %b",
                        $time, want.pixel_on, rsp_pixel_on);
               failures++;
            end
         end
      end
   end

   // run limit
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("micro_bus_io_decoder_core test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Sequencing
   // ---------------------------------------------------------------
   task automatic wait_for_drain();
      while (pending.size() != 0 || req_valid || result_fifo.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_reset_vector(input logic [15:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      reset_vector_m = value;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: vector reset value, vsync set/clear, stubs, unmapped port,
      // RAM ends, scan hit and miss with bit 7 set, alternate screen base
      // with the first and last pixel, a spare operation with all ones
      add_request(mbd_pkg::OP_READ,  mbd_pkg::ADDR_VEC_LO, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_READ,  mbd_pkg::ADDR_VEC_HI, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_READ,  mbd_pkg::ADDR_SYNC, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_FRAME, 16'h0000, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_READ,  mbd_pkg::ADDR_SYNC, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_WRITE, mbd_pkg::ADDR_SYNC, 8'hFF, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_READ,  mbd_pkg::ADDR_SYNC, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_READ,  mbd_pkg::ADDR_STUB_A, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_READ,  mbd_pkg::ADDR_STUB_B, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_READ,  ADDR_UNMAPPED_PORT, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_WRITE, 16'h0000, 8'hA5, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_WRITE, 16'h7FFF, 8'h5A, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_READ,  16'h0000, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_READ,  16'h7FFF, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_WRITE, mbd_pkg::ADDR_SCAN, {1'b1, mbd_pkg::SCAN_Z}, 4'h0,
                  8'h00, 8'h00);
      add_request(mbd_pkg::OP_KEYS,  16'h0000, 8'h00, 4'h1, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_READ,  mbd_pkg::ADDR_SCAN, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_KEYS,  16'h0000, 8'h00, 4'hE, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_READ,  mbd_pkg::ADDR_SCAN, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_WRITE, mbd_pkg::ADDR_CRTC_SEL, mbd_pkg::CRTC_START_HIGH,
                  4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_WRITE, mbd_pkg::ADDR_CRTC_DATA, mbd_pkg::START_HIGH_ALT,
                  4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_WRITE, SCREEN_BASE_ALT, 8'h80, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_PIXEL, 16'h0000, 8'h00, 4'h0, 8'h00, 8'h00);
      add_request(mbd_pkg::OP_PIXEL, 16'h0000, 8'h00, 4'h0, 8'hFF, 8'hFF);
      add_request(OP_SPARE_HI, 16'hFFFF, 8'hFF, 4'hF, 8'hFF, 8'hFF);
      wait_for_drain();

      // random phases, each under its own reset vector
      write_reset_vector(16'h0000);
      drain_next = 1'b1;
      plan_random_phase(PHASE_ITEMS);
      wait_for_drain();

      // back-to-back stretch: no sender or receiver gaps
      write_reset_vector(16'hFFFF);
      idle_on = 1'b0;
      plan_random_phase(PHASE_ITEMS);
      wait_for_drain();

      write_reset_vector(rnd16());
      idle_on = 1'b1;
      plan_random_phase(PHASE_ITEMS);
      wait_for_drain();

      if (failures == 0 && result_fifo.size() == 0) begin
         $display("micro_bus_io_decoder_core test passed");
      end else begin
         $display("micro_bus_io_decoder_core test failed");
      end
      $finish;
   end

endmodule
